// ===== sv/lgww_pkg.sv =====
// Shared types and constants for the graphic window writer.
package lgww_pkg;

    localparam int HALF_ROWS  = 32;
    localparam int ADDR_W     = 4;
    localparam int MAX_TXN    = 4;
    localparam int TXN_CNT_W  = $clog2(MAX_TXN + 1);

    localparam logic [7:0] CMD_GRAPHIC = 8'h36;
    localparam logic [7:0] CMD_ADDR    = 8'h80;
    localparam logic [7:0] CLEAR_BYTE  = 8'h00;

    localparam logic [4:0] MAX_WIDTH  = 5'd16;
    localparam logic [6:0] MAX_HEIGHT = 7'd64;

    localparam logic [5:0] HALF_ROWS_V = 6'(HALF_ROWS);

    // register indexes
    localparam logic [1:0] REG_START_COLUMN  = 2'd0;
    localparam logic [1:0] REG_START_ROW     = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_ROW = 2'd2;
    localparam logic [1:0] REG_ROW_COUNT     = 2'd3;

    typedef struct packed {
        logic [2:0] start_column;
        logic [5:0] start_row;
        logic [4:0] bytes_per_row;
        logic [6:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
    } txn_t;

    // one image byte expands into up to four transactions, head in slot 0
    typedef struct packed {
        txn_t [MAX_TXN-1:0]   txn;
        logic [TXN_CNT_W-1:0] count;
    } group_t;

endpackage

// ===== sv/lgww_apb_regs.sv =====
// APB configuration registers of the window writer.
module lgww_apb_regs
    import lgww_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_column  <= 3'd0;
            cfg_reg.start_row     <= 6'd0;
            cfg_reg.bytes_per_row <= MAX_WIDTH;
            cfg_reg.row_count     <= MAX_HEIGHT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_COLUMN:  cfg_reg.start_column  <= pwdata[2:0];
                REG_START_ROW:     cfg_reg.start_row     <= pwdata[5:0];
                REG_BYTES_PER_ROW: cfg_reg.bytes_per_row <= pwdata[4:0];
                REG_ROW_COUNT:     cfg_reg.row_count     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_COLUMN:  prdata = {29'd0, cfg_reg.start_column};
            REG_START_ROW:     prdata = {26'd0, cfg_reg.start_row};
            REG_BYTES_PER_ROW: prdata = {27'd0, cfg_reg.bytes_per_row};
            REG_ROW_COUNT:     prdata = {25'd0, cfg_reg.row_count};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/lgww_seq.sv =====
// Window position counters and expansion of one image byte into bus transactions.
module lgww_seq
    import lgww_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_fire,
    input  logic       mode,
    input  logic [7:0] pixel_byte,
    output group_t     grp
);

    logic [3:0] byte_in_row_reg, byte_in_row_next;
    logic [6:0] row_index_reg,   row_index_next;
    logic       window_open_reg, window_open_next;

    logic [4:0] width;
    logic [6:0] height;
    logic [5:0] row_raw, row_addr;
    logic [3:0] col_addr;
    logic       row_start, row_end, win_end;
    txn_t       t_mode, t_row, t_col, t_data;

    always_comb begin
        width = cfg.bytes_per_row;
        if (width == 5'd0)     width = 5'd1;
        if (width > MAX_WIDTH) width = MAX_WIDTH;
        height = cfg.row_count;
        if (height == 7'd0)      height = 7'd1;
        if (height > MAX_HEIGHT) height = MAX_HEIGHT;
    end

    // fold lower half of the panel onto the right half of the address map
    always_comb begin
        row_raw  = cfg.start_row + row_index_reg[5:0];
        row_addr = row_raw;
        col_addr = {1'b0, cfg.start_column};
        if (row_raw >= HALF_ROWS_V) begin
            row_addr = row_raw - HALF_ROWS_V;
            col_addr = {1'b0, cfg.start_column} + 4'd8;
        end
    end

    assign row_start = (byte_in_row_reg == 4'd0);
    assign row_end   = ({1'b0, byte_in_row_reg} + 5'd1) >= width;
    assign win_end   = ({1'b0, row_index_reg} + 8'd1) >= {1'b0, height};

    assign t_mode = '{is_data: 1'b0, bus_byte: CMD_GRAPHIC};
    assign t_row  = '{is_data: 1'b0, bus_byte: CMD_ADDR | {2'b00, row_addr}};
    assign t_col  = '{is_data: 1'b0, bus_byte: CMD_ADDR | {4'h0, col_addr}};
    assign t_data = '{is_data: 1'b1, bus_byte: mode ? CLEAR_BYTE : pixel_byte};

    always_comb begin
        grp.txn = '0;
        case ({window_open_reg, row_start})
            2'b01: begin
                grp.txn[0] = t_mode;
                grp.txn[1] = t_row;
                grp.txn[2] = t_col;
                grp.txn[3] = t_data;
                grp.count  = TXN_CNT_W'(4);
            end
            2'b00: begin
                grp.txn[0] = t_mode;
                grp.txn[1] = t_data;
                grp.count  = TXN_CNT_W'(2);
            end
            2'b11: begin
                grp.txn[0] = t_row;
                grp.txn[1] = t_col;
                grp.txn[2] = t_data;
                grp.count  = TXN_CNT_W'(3);
            end
            default: begin
                grp.txn[0] = t_data;
                grp.count  = TXN_CNT_W'(1);
            end
        endcase
    end

    always_comb begin
        byte_in_row_next = byte_in_row_reg;
        row_index_next   = row_index_reg;
        window_open_next = window_open_reg;
        if (s_fire) begin
            window_open_next = 1'b1;
            if (row_end) begin
                byte_in_row_next = 4'd0;
                if (win_end) begin
                    row_index_next   = 7'd0;
                    window_open_next = 1'b0;
                end else begin
                    row_index_next = row_index_reg + 7'd1;
                end
            end else begin
                byte_in_row_next = byte_in_row_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_row_reg <= 4'd0;
            row_index_reg   <= 7'd0;
            window_open_reg <= 1'b0;
        end else begin
            byte_in_row_reg <= byte_in_row_next;
            row_index_reg   <= row_index_next;
            window_open_reg <= window_open_next;
        end
    end

    // a closed window always sits at its start position
    a_closed_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !window_open_reg |-> (byte_in_row_reg == 4'd0 && row_index_reg == 7'd0))
        else $error("window closed away from its start");

    a_close_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && row_end && win_end) |=> !window_open_reg)
        else $error("window did not close after its last byte");

    a_open_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !(row_end && win_end)) |=> window_open_reg)
        else $error("window not open after a mid-window byte");

endmodule

// ===== sv/lgww_out.sv =====
// Result register that shifts out one bus transaction per beat.
module lgww_out
    import lgww_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  group_t     grp,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       s_fire,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_data,
    output logic [7:0] m_bus_byte,
    output logic       m_last
);

    txn_t [MAX_TXN-1:0]   txn_reg, txn_next;
    logic [TXN_CNT_W-1:0] rem_reg, rem_next;
    logic                 valid_reg, valid_next;
    logic                 pop;

    assign pop     = valid_reg && m_ready;
    assign s_ready = !valid_reg || (m_ready && rem_reg == TXN_CNT_W'(1));
    assign s_fire  = s_valid && s_ready;

    assign m_valid    = valid_reg;
    assign m_is_data  = txn_reg[0].is_data;
    assign m_bus_byte = txn_reg[0].bus_byte;
    assign m_last     = (rem_reg == TXN_CNT_W'(1));

    always_comb begin
        txn_next   = txn_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        if (s_fire) begin
            txn_next   = grp.txn;
            rem_next   = grp.count;
            valid_next = 1'b1;
        end else if (pop) begin
            for (int i = 0; i < MAX_TXN - 1; i++) begin
                txn_next[i] = txn_reg[i+1];
            end
            txn_next[MAX_TXN-1] = '0;
            rem_next   = rem_reg - TXN_CNT_W'(1);
            valid_next = (rem_reg != TXN_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        txn_reg <= txn_next;
        if (!aresetn) begin
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (rem_reg != '0 && rem_reg <= TXN_CNT_W'(MAX_TXN)))
        else $error("held group has no transactions left");

    // the data write closes every group, commands come before it
    a_data_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (txn_reg[0].is_data == (rem_reg == TXN_CNT_W'(1))))
        else $error("data write out of place in group");

    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && rem_reg != TXN_CNT_W'(1)) |=>
            (valid_reg && rem_reg == $past(rem_reg) - TXN_CNT_W'(1)))
        else $error("group did not advance by one transaction");

endmodule

// ===== sv/lcd_graphic_window_writer_unit.sv =====
// Top level of the graphic window writer: registers, sequencer and output stage.
//
// Turns a stream of image bytes for a rectangular window of a 128x64 graphic
// display into bus transactions (command or data byte), one per output beat.
// A byte in the middle of a row gives one data write; the first byte of a row
// adds a row and a column address command ahead of it (3 beats), and the first
// byte of a window adds the graphic-mode command as well (4 beats). The output
// stage shifts out one transaction per cycle while m_ready is held high; the
// next byte is taken in the same cycle that the last transaction of the
// previous one leaves, so there is no bubble between bytes. Window
// geometry is set over APB and should only be changed while no byte is in
// flight.
module lcd_graphic_window_writer_unit
    import lgww_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [7:0]        s_pixel_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_data,
    output logic [7:0]        m_bus_byte,
    output logic              m_last
);

    cfg_t   cfg;
    group_t grp;
    logic   s_fire;

    lgww_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lgww_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_fire     (s_fire),
        .mode       (s_mode),
        .pixel_byte (s_pixel_byte),
        .grp        (grp)
    );

    lgww_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .grp        (grp),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_fire     (s_fire),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_data  (m_is_data),
        .m_bus_byte (m_bus_byte),
        .m_last     (m_last)
    );

endmodule
